FILE: hdl/linear_probe_hash_table_unit_assert.svh
// assertion macros used by the hash table checker
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LPHT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht check failed (same cycle)");

// consequent must hold in the cycle after the antecedent
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht check failed (next cycle)");

`endif

FILE: hdl/lpht_pkg.sv
// shared widths, codes and helpers of the linear probe hash table
package lpht_pkg;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned KEY_W     = 31;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned PROBES_W  = 5;
  localparam int unsigned PROBE_MAX = 31;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_MISS     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd4;

  // probe count clamped to the result field
  function automatic logic [PROBES_W-1:0] sat_probes(input int unsigned n);
    logic [PROBES_W-1:0] r;
    r = (n > PROBE_MAX) ? PROBES_W'(PROBE_MAX) : PROBES_W'(n);
    return r;
  endfunction

endpackage

FILE: hdl/lpht_if.sv
// request and response channel interfaces of the hash table
interface lpht_in_if import lpht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;

  modport source (output valid, func, key, input ready);
  modport sink   (input valid, func, key, output ready);
endinterface

interface lpht_out_if import lpht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [PROBES_W-1:0] probes;

  modport source (output valid, status, slot, probes, input ready);
  modport sink   (input valid, status, slot, probes, output ready);
endinterface

FILE: hdl/linear_probe_hash_table_unit.sv
// open-addressing hash table with linear probing: top level
// The table holds TABLE_SIZE entries of a 31-bit key, the probe count it was stored with and
// a used bit, all in one single-port-write, single-port-read memory with registered read
// data. Items are taken one at a time; the request channel is ready only while the unit is
// idle, and a finished result sits in an output register, so a new request can be taken
// while the previous result still waits for its transfer. Insert and search visit one slot
// per cycle through the memory read port: an item is accepted, probes k slots
// (k = 1 .. TABLE_SIZE, the slots examined) and then loads the output register once it is free. When
// TABLE_SIZE is not a power of two the home slot is found first by a multiply with the
// rounded-up reciprocal of the table size and a small back-multiply, in S_MOD and S_HOME; for a
// power of two it is the low key bits.
// Clear sweeps the memory one entry per cycle. After reset the same sweep runs with no
// request taken and no result given.
// Results: status 0 inserted, 1 found, 2 not found, 3 table full, 4 cleared; slot holds
// the low four bits of the slot index; probes saturates at 31. Duplicate keys are stored.
module linear_probe_hash_table_unit import lpht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpht_in_if.sink    in_i,
  lpht_out_if.source out_o
);

  localparam int unsigned IDX_W   = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W   = $clog2(TABLE_SIZE + 1);
  localparam bit          IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
  localparam int unsigned RECIP_W = KEY_W + 1;
  localparam int unsigned PROD_W  = KEY_W + RECIP_W;
  localparam int unsigned MOD_SH  = KEY_W + IDX_W;
  // rounded-up reciprocal: the quotient is exact for every 31-bit key
  localparam logic [RECIP_W-1:0] MOD_RECIP =
    RECIP_W'(((64'd1 << MOD_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

  // one table entry as stored in memory
  typedef struct packed {
    logic                used;
    logic [PROBES_W-1:0] probes;
    logic [KEY_W-1:0]    key;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLR,    // clearing sweep, after reset or on a clear request
    S_IDLE,   // waiting for a request
    S_MOD,    // quotient of key by table size
    S_HOME,   // remainder gives the home slot
    S_PROBE,  // one slot examined per cycle
    S_DONE    // result waits for the output register
  } state_e;

  state_e              state_q;
  logic [FUNC_W-1:0]   func_q;
  logic [KEY_W-1:0]    key_q;
  logic [IDX_W-1:0]    pos_q;      // probe position, also the sweep pointer
  logic [CNT_W-1:0]    cnt_q;      // slots examined so far, from 1
  logic [IDX_W-1:0]    quot_q;     // low bits of the quotient
  logic                clr_rsp_q;  // sweep was asked for and needs a result
  logic [STATUS_W-1:0] res_status_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic [PROBES_W-1:0] res_probes_q;
  logic                out_vld_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [PROBES_W-1:0] out_probes_q;

  // table memory
  entry_t              mem [TABLE_SIZE];
  entry_t              rd_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  entry_t              wr_data;

  // shared arithmetic
  logic [PROD_W-1:0]   mod_prod;
  logic [IDX_W-1:0]    mod_home;
  logic [IDX_W-1:0]    pos_inc;
  logic                slot_free;
  logic                slot_hit;
  logic                walk_last;
  logic [PROBES_W-1:0] cnt_sat;

  // key times reciprocal, quotient sits from bit MOD_SH upward
  assign mod_prod = PROD_W'(key_q) * PROD_W'(MOD_RECIP);
  // remainder is below the table size, so its low bits are all that matter
  assign mod_home = key_q[IDX_W-1:0] - quot_q * IDX_W'(TABLE_SIZE);

  // next slot with wraparound
  assign pos_inc = (pos_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : pos_q + 1'b1;

  assign slot_free = !rd_q.used;
  assign slot_hit  = rd_q.used && (rd_q.key == key_q);
  assign walk_last = (cnt_q == CNT_W'(TABLE_SIZE));
  assign cnt_sat   = sat_probes(32'(cnt_q));

  // read address runs one slot ahead so that the probe loop sees fresh data each cycle
  always_comb begin
    case (state_q)
      S_IDLE:  rd_addr = in_i.key[IDX_W-1:0];  // home slot for a power-of-two table
      S_HOME:  rd_addr = mod_home;             // home slot from the remainder
      S_PROBE: rd_addr = pos_inc;
      default: rd_addr = pos_q;
    endcase
  end

  // writes: clearing sweep, or the key going into the first free slot
  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if (state_q == S_CLR) begin
      wr_en = 1'b1;
    end else if (state_q == S_PROBE && func_q == FUNC_INSERT && slot_free) begin
      wr_en   = 1'b1;
      wr_data = '{used: 1'b1, probes: cnt_sat, key: key_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[pos_q] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      func_q       <= '0;
      key_q        <= '0;
      pos_q        <= '0;
      cnt_q        <= '0;
      quot_q       <= '0;
      clr_rsp_q    <= 1'b0;
      res_status_q <= '0;
      res_slot_q   <= '0;
      res_probes_q <= '0;
      out_vld_q    <= 1'b0;
      out_status_q <= '0;
      out_slot_q   <= '0;
      out_probes_q <= '0;
    end else begin
      // result transfer frees the output register unless a new result moves in
      if (out_vld_q && out_o.ready && state_q != S_DONE) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_CLR: begin
          if (pos_q == IDX_W'(TABLE_SIZE - 1)) begin
            pos_q     <= '0;
            clr_rsp_q <= 1'b0;
            if (clr_rsp_q) begin
              res_status_q <= STAT_CLEARED;
              res_slot_q   <= '0;
              res_probes_q <= '0;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_i.valid) begin
            func_q <= in_i.func;
            key_q  <= in_i.key;
            cnt_q  <= CNT_W'(1);
            case (in_i.func)
              FUNC_INSERT, FUNC_SEARCH: begin
                pos_q <= in_i.key[IDX_W-1:0];
                if (IS_POW2) begin
                  state_q <= S_PROBE;
                end else begin
                  state_q <= S_MOD;
                end
              end
              FUNC_CLEAR: begin
                pos_q     <= '0;
                clr_rsp_q <= 1'b1;
                state_q   <= S_CLR;
              end
              default: begin
                // undefined operation: table untouched, reported as a miss
                res_status_q <= STAT_MISS;
                res_slot_q   <= '0;
                res_probes_q <= '0;
                state_q      <= S_DONE;
              end
            endcase
          end
        end

        S_MOD: begin
          quot_q  <= IDX_W'(mod_prod >> MOD_SH);
          state_q <= S_HOME;
        end

        S_HOME: begin
          pos_q   <= mod_home;
          state_q <= S_PROBE;
        end

        S_PROBE: begin
          if (func_q == FUNC_INSERT) begin
            if (slot_free) begin
              res_status_q <= STAT_INSERTED;
              res_slot_q   <= SLOT_W'(pos_q);
              res_probes_q <= cnt_sat;
              state_q      <= S_DONE;
            end else if (walk_last) begin
              res_status_q <= STAT_FULL;
              res_slot_q   <= '0;
              res_probes_q <= cnt_sat;
              state_q      <= S_DONE;
            end else begin
              pos_q <= pos_inc;
              cnt_q <= cnt_q + 1'b1;
            end
          end else begin
            if (slot_free || (walk_last && !slot_hit)) begin
              // free slot ends the chain, or every slot has been seen
              res_status_q <= STAT_MISS;
              res_slot_q   <= '0;
              res_probes_q <= cnt_sat;
              state_q      <= S_DONE;
            end else if (slot_hit) begin
              res_status_q <= STAT_FOUND;
              res_slot_q   <= SLOT_W'(pos_q);
              res_probes_q <= cnt_sat;
              state_q      <= S_DONE;
            end else begin
              pos_q <= pos_inc;
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end

        S_DONE: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q    <= 1'b1;
            out_status_q <= res_status_q;
            out_slot_q   <= res_slot_q;
            out_probes_q <= res_probes_q;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = out_vld_q;
  assign out_o.status = out_status_q;
  assign out_o.slot   = out_slot_q;
  assign out_o.probes = out_probes_q;

endmodule

FILE: hdl/lpht_checker.sv
// port-level checker of the hash table result channel, with its bind
`include "linear_probe_hash_table_unit_assert.svh"

module lpht_checker import lpht_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] out_status_i,
  input logic [SLOT_W-1:0]   out_slot_i,
  input logic [PROBES_W-1:0] out_probes_i
);

  // a pending result stays offered until its transfer
  `LPHT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a stalled result keeps its payload
  `LPHT_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_status_i) && $stable(out_slot_i) && $stable(out_probes_i))

  // only the five defined status codes appear
  `LPHT_ASSERT_SAME(a_status_code, clk_i, rst_ni, out_valid_i, out_status_i <= STAT_CLEARED)

  // slot is zero unless a key was written or found
  `LPHT_ASSERT_SAME(a_slot_zero, clk_i, rst_ni, out_valid_i && (out_status_i == STAT_MISS || out_status_i == STAT_FULL || out_status_i == STAT_CLEARED), out_slot_i == '0)

  // a stored or found key has examined at least its home slot; clear examines none
  `LPHT_ASSERT_SAME(a_probe_count, clk_i, rst_ni, out_valid_i && (out_status_i == STAT_INSERTED || out_status_i == STAT_FOUND || out_status_i == STAT_CLEARED), (out_status_i == STAT_CLEARED) == (out_probes_i == '0))

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_slot_i   (out_o.slot),
  .out_probes_i (out_o.probes)
);

FILE: tb/sv/linear_probe_hash_table_unit_tb.sv
// testbench for the linear probe hash table: directed and random requests checked against a predictor
module linear_probe_hash_table_unit_tb;
  import lpht_pkg::*;

  localparam int unsigned TABLE_SIZE  = 16;
  localparam int unsigned RAND_TARGET = 650;   // least total of requests, directed ones included
  localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int unsigned HOLD_AT     = 40;    // requests sent before the hold-off starts
  localparam int unsigned STALL_LIMIT = 4000;  // cycles without any transfer before giving up
  localparam int unsigned DRAIN_WAIT  = 40;    // cycles to watch for stray results at the end
  localparam int unsigned SHOW_MAX    = 10;

  // func 3 has no meaning; the unit must answer it as a miss and leave the table alone
  localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0]  key;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [PROBES_W-1:0] probes;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lpht_in_if  req_bus ();
  lpht_out_if rsp_bus ();

  linear_probe_hash_table_unit #(
    .TABLE_SIZE(TABLE_SIZE)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_bus.sink),
    .out_o (rsp_bus.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the table contents, updated as each request transfer happens
  logic [KEY_W-1:0] tbl_key  [TABLE_SIZE];
  logic             tbl_used [TABLE_SIZE];

  request_t    pending_requests [$];
  reply_t      expected_replies [$];
  int unsigned total_requests;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned mismatches;
  int unsigned status_seen [5];
  int unsigned idle_cycles;
  int unsigned hold_left;
  bit          hold_done;
  reply_t      got_reply;
  reply_t      want_reply;

  function automatic logic [PROBES_W-1:0] probe_clamp(input int unsigned n);
    return (n > PROBE_MAX) ? PROBES_W'(PROBE_MAX) : PROBES_W'(n);
  endfunction

  // applies one request to the mirrored table and returns the reply the unit owes
  function automatic reply_t hash_table_predict(input logic [FUNC_W-1:0] op,
                                                input logic [KEY_W-1:0] k);
    reply_t      r;
    int unsigned pos;
    int unsigned n;
    bit          done;
    r.status = STAT_MISS;
    r.slot   = '0;
    r.probes = '0;
    pos      = k % TABLE_SIZE;
    done     = 1'b0;
    case (op)
      FUNC_INSERT: begin
        // default outcome: every slot taken
        r.status = STAT_FULL;
        r.probes = probe_clamp(TABLE_SIZE);
        for (n = 1; n <= TABLE_SIZE; n++) begin
          if (!done && !tbl_used[pos]) begin
            tbl_used[pos] = 1'b1;
            tbl_key[pos]  = k;
            r.status      = STAT_INSERTED;
            r.slot        = SLOT_W'(pos);
            r.probes      = probe_clamp(n);
            done          = 1'b1;
          end
          pos = (pos + 1) % TABLE_SIZE;
        end
      end
      FUNC_SEARCH: begin
        // a full table without the key ends after one lap
        r.probes = probe_clamp(TABLE_SIZE);
        for (n = 1; n <= TABLE_SIZE; n++) begin
          if (!done) begin
            if (!tbl_used[pos]) begin
              r.probes = probe_clamp(n);
              done     = 1'b1;
            end else if (tbl_key[pos] == k) begin
              r.status = STAT_FOUND;
              r.slot   = SLOT_W'(pos);
              r.probes = probe_clamp(n);
              done     = 1'b1;
            end
          end
          pos = (pos + 1) % TABLE_SIZE;
        end
      end
      FUNC_CLEAR: begin
        for (n = 0; n < TABLE_SIZE; n++) begin
          tbl_used[n] = 1'b0;
          tbl_key[n]  = '0;
        end
        r.status = STAT_CLEARED;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned idle_phase();
    return (total_requests == 0) ? 0 : (sent_count * 4) / total_requests;
  endfunction

  // phase 0 no idling, 1 sender gaps, 2 receiver stalls, 3 both lighter
  function automatic bit sender_pauses();
    case (idle_phase())
      1:       return $urandom_range(0, 99) < 61;
      3:       return $urandom_range(0, 99) < 23;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    if (hold_left != 0) return 1'b1;
    case (idle_phase())
      2:       return $urandom_range(0, 99) < 61;
      3:       return $urandom_range(0, 99) < 23;
      default: return 1'b0;
    endcase
  endfunction

  task automatic push_request(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k);
    request_t q;
    q.op  = op;
    q.key = k;
    pending_requests.push_back(q);
  endtask

  task automatic note_mismatch(input string what, input reply_t want, input reply_t got);
    mismatches++;
    if (mismatches <= SHOW_MAX)
      $display("%0t: %s: expected status %0d slot %0d probes %0d, got status %0d slot %0d probes %0d",
               $realtime, what, want.status, want.slot, want.probes,
               got.status, got.slot, got.probes);
  endtask

  // builds one burst of requests around a small pool of colliding keys, so that
  // probe chains get long, duplicates appear and the table sometimes fills up
  task automatic add_random_burst();
    logic [KEY_W-1:0] pool [6];
    logic [3:0]       home;
    logic [KEY_W-1:0] k;
    int unsigned      ops;
    int unsigned      insert_pct;
    int unsigned      pick;
    int unsigned      i;
    home = 4'($urandom_range(0, 15));
    for (i = 0; i < 6; i++) begin
      pool[i]      = KEY_W'($urandom());
      pool[i][3:0] = home + 4'(i % 3);
    end
    if ($urandom_range(0, 3) == 0) push_request(FUNC_CLEAR, KEY_W'($urandom()));
    ops        = $urandom_range(4, 30);
    insert_pct = ($urandom_range(0, 4) == 0) ? 85 : 50;
    for (i = 0; i < ops; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        k = pool[$urandom_range(0, 5)];
      else if (pick < 9)
        k = KEY_W'($urandom());
      else
        k = $urandom_range(0, 1) ? '1 : KEY_W'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < insert_pct)
        push_request(FUNC_INSERT, k);
      else if (pick < 96)
        push_request(FUNC_SEARCH, k);
      else if (pick < 98)
        push_request(FUNC_UNDEF, k);
      else
        push_request(FUNC_CLEAR, k);
    end
  endtask

  // request driver: holds the payload until the unit takes it, predicts on transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      req_bus.func  <= FUNC_INSERT;
      req_bus.key   <= '0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        expected_replies.push_back(hash_table_predict(req_bus.func, req_bus.key));
        void'(pending_requests.pop_front());
        sent_count++;
      end
      if (req_bus.valid && !req_bus.ready) begin
        // offer stays up unchanged
      end else if (pending_requests.size() != 0 && !sender_pauses()) begin
        req_bus.valid <= 1'b1;
        req_bus.func  <= pending_requests[0].op;
        req_bus.key   <= pending_requests[0].key;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // one long hold-off of the receiver while requests keep coming, to back the unit up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: each transfer is checked against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got_reply.status = rsp_bus.status;
        got_reply.slot   = rsp_bus.slot;
        got_reply.probes = rsp_bus.probes;
        if (got_reply.status < 5) status_seen[got_reply.status]++;
        if (expected_replies.size() == 0) begin
          note_mismatch("result with nothing pending", '0, got_reply);
        end else begin
          want_reply = expected_replies.pop_front();
          checked_count++;
          if (got_reply.status !== want_reply.status ||
              got_reply.slot   !== want_reply.slot   ||
              got_reply.probes !== want_reply.probes)
            note_mismatch("result mismatch", want_reply, got_reply);
        end
      end
      rsp_bus.ready <= !receiver_stalls();
    end
  end

  // watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int unsigned s;
    total_requests = 0;
    sent_count     = 0;
    checked_count  = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    for (s = 0; s < 5; s++) status_seen[s] = 0;
    for (s = 0; s < TABLE_SIZE; s++) begin
      tbl_used[s] = 1'b0;
      tbl_key[s]  = '0;
    end

    // directed: empty table, undefined op, wrap-around, fill to full, full-table
    // insert and miss, then clear and look again
    push_request(FUNC_SEARCH, KEY_W'(5));
    push_request(FUNC_UNDEF, '1);
    push_request(FUNC_INSERT, '1);
    push_request(FUNC_INSERT, KEY_W'(15));
    push_request(FUNC_INSERT, '0);
    for (s = 2; s <= 14; s++)
      push_request(FUNC_INSERT, (s[0] ? 31'h5555_5550 : 31'h2AAA_AAA0) | KEY_W'(s));
    push_request(FUNC_SEARCH, KEY_W'(15));
    push_request(FUNC_INSERT, KEY_W'(7));
    push_request(FUNC_SEARCH, KEY_W'(99));
    push_request(FUNC_CLEAR, '1);
    push_request(FUNC_SEARCH, KEY_W'(15));

    while (pending_requests.size() < RAND_TARGET) add_random_burst();
    total_requests = pending_requests.size();

    rst_ni = 1'b1;
    #1 rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_count < total_requests || expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("sent %0d requests, checked %0d results", sent_count, checked_count);
    $display("inserted %0d, found %0d, missed %0d, full %0d, cleared %0d",
             status_seen[STAT_INSERTED], status_seen[STAT_FOUND], status_seen[STAT_MISS],
             status_seen[STAT_FULL], status_seen[STAT_CLEARED]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
